// ----- rtl/core/bba_pkg.sv -----
// Shared types and constants of the buddy block allocator.
`default_nettype none
package bba_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned LV_W   = 5;
    localparam int unsigned MIN_W  = 5;
    localparam int unsigned WIDE_W = 40;
    localparam int unsigned CIDX_W = 2;

    localparam logic [MIN_W-1:0] MIN_LOG2_CAP = 5'd20;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CIDX_W-1:0] REG_BASE   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_LEVELS = 2'd1;
    localparam logic [CIDX_W-1:0] REG_MINLOG = 2'd2;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_ARD   = 10'b0000000100,
        S_AEV   = 10'b0000001000,
        S_BACK  = 10'b0000010000,
        S_FRD   = 10'b0000100000,
        S_FEV   = 10'b0001000000,
        S_MRD   = 10'b0010000000,
        S_MEV   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/core/buddy_block_allocator_unit.sv -----
// Top level of the buddy block allocator: tree walker over two bit-map memories.
// Alloc reads and evaluates each tree node visited (S_ARD, S_AEV) and backtracks through S_BACK;
// free probes each ancestor (S_FRD, S_FEV), then merges (S_MRD, S_MEV); S_DONE loads the output register.
// One request at a time; a rejected one goes straight from S_IDLE to S_DONE.
// Reset (synchronous, active low) and any configuration write to base, levels or minlog start a
// clearing pass over all 2*MAX_LEAVES entries of both memories, during which no request is accepted.
`default_nettype none
module buddy_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int unsigned MAX_LEAVES = 2048
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [63:0]         s_axis_tdata,  // [31:0] request_size, [63:32] free_address
    input  wire logic                s_axis_tuser,  // [0] operation
    // result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [39:0]              m_axis_tdata,  // [31:0] block_address, [33:32] status
    // configuration writes
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CIDX_W-1:0]   i_cfg_index,
    input  wire logic [ADDR_W-1:0]   i_cfg_data
);

    function automatic int unsigned f_floor_log2(input int unsigned v);
        int unsigned n;
        n = 0;
        while ((64'd2 << n) <= 64'(v)) n++;
        return n;
    endfunction

    localparam int unsigned DEPTH   = 2 * MAX_LEAVES;
    localparam int unsigned NW      = $clog2(DEPTH);
    localparam int unsigned LVL_CAP = f_floor_log2(MAX_LEAVES);

    // bit-map memories, one write port, two read ports each
    logic mem_used  [DEPTH];
    logic mem_split [DEPTH];

    t_state r_state, n_state;

    logic [ADDR_W-1:0] r_base;
    logic [3:0]        r_levels;
    logic [MIN_W-1:0]  r_minlog;

    logic [NW-1:0]     r_clr;
    logic [NW-1:0]     r_node, n_node;
    logic [LV_W-1:0]   r_depth, n_depth;
    logic [WIDE_W-1:0] r_span, n_span;
    logic [WIDE_W-1:0] r_off, n_off;
    logic [ADDR_W-1:0] r_req, n_req;

    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [STAT_W-1:0] r_res_st, n_res_st;

    logic              r_m_valid;
    logic [ADDR_W-1:0] r_m_addr;
    logic [STAT_W-1:0] r_m_st;

    // registered read data: port A at the current node, port B at its buddy
    logic r_ua, r_sa, r_ub, r_sb;

    logic              we_u, wd_u, we_s, wd_s;
    logic [NW-1:0]     wa_u, wa_s;

    logic [LV_W-1:0]   lv;
    logic [MIN_W-1:0]  mlog;
    logic [WIDE_W-1:0] pool;
    logic [WIDE_W-1:0] half;
    logic              is_leaf, too_big;
    logic [NW-1:0]     buddy, parent;
    logic [ADDR_W-1:0] disp;
    logic [ADDR_W-1:0] dmask;
    logic [ADDR_W-1:0] dleaf;
    logic [NW-1:0]     leaf_node;
    logic              in_xfer, cfg_xfer, out_load;

    // saturate the configuration to what the tree can hold
    assign lv   = ({1'b0, r_levels} > LV_W'(LVL_CAP)) ? LV_W'(LVL_CAP) : {1'b0, r_levels};
    assign mlog = (r_minlog > MIN_LOG2_CAP) ? MIN_LOG2_CAP : r_minlog;
    assign pool = WIDE_W'(1) << (6'(lv) + 6'(mlog));

    assign half    = r_span >> 1;
    assign is_leaf = (r_depth >= lv);
    assign too_big = ({{(WIDE_W-ADDR_W){1'b0}}, r_req} > half);
    assign buddy   = r_node[0] ? (r_node + NW'(1)) : (r_node - NW'(1));
    assign parent  = (r_node - NW'(1)) >> 1;

    // free address to leaf node
    assign disp      = s_axis_tdata[63:32] - r_base;
    assign dmask     = ~({ADDR_W{1'b1}} << mlog);
    assign dleaf     = disp >> mlog;
    assign leaf_node = (NW'(1) << lv) - NW'(1) + dleaf[NW-1:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_xfer      = i_cfg_valid;
    assign out_load      = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_m_st, r_m_addr};

    always_comb begin
        n_state    = r_state;
        n_node     = r_node;
        n_depth    = r_depth;
        n_span     = r_span;
        n_off      = r_off;
        n_req      = r_req;
        n_res_addr = r_res_addr;
        n_res_st   = r_res_st;
        we_u = 1'b0; wa_u = r_node; wd_u = 1'b0;
        we_s = 1'b0; wa_s = r_node; wd_s = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                we_u = 1'b1; wa_u = r_clr;
                we_s = 1'b1; wa_s = r_clr;
                if (r_clr == NW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_res_addr = '0;
                    n_res_st   = ST_OK;
                    n_req      = s_axis_tdata[31:0];
                    if (s_axis_tuser == OP_ALLOC) begin
                        n_node  = '0;
                        n_depth = '0;
                        n_span  = pool;
                        n_off   = '0;
                        if ({{(WIDE_W-ADDR_W){1'b0}}, s_axis_tdata[31:0]} > pool) begin
                            n_res_st = ST_NOSPACE;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_ARD;
                        end
                    end else begin
                        if ({{(WIDE_W-ADDR_W){1'b0}}, disp} >= pool || (disp & dmask) != '0)
                        begin
                            n_res_st = ST_BADFREE;
                            n_state  = S_DONE;
                        end else begin
                            n_node  = leaf_node;
                            n_state = S_FRD;
                        end
                    end
                end
            end
            S_ARD: n_state = S_AEV;
            S_AEV: begin
                if (r_ua) begin
                    n_state = S_BACK;
                end else if ((too_big || is_leaf) && !r_sa) begin
                    we_u = 1'b1; wd_u = 1'b1;
                    n_res_addr = r_base + r_off[ADDR_W-1:0];
                    n_state    = S_DONE;
                end else if (is_leaf || too_big) begin
                    n_state = S_BACK;
                end else begin
                    // split and descend into the lower half
                    we_s = 1'b1; wd_s = 1'b1;
                    n_node  = {r_node[NW-2:0], 1'b1};
                    n_depth = r_depth + LV_W'(1);
                    n_span  = half;
                    n_state = S_ARD;
                end
            end
            S_BACK: begin
                priority if (r_node == '0) begin
                    n_res_st = ST_NOSPACE;
                    n_state  = S_DONE;
                end else if (r_node[0]) begin
                    n_node  = r_node + NW'(1);
                    n_off   = r_off + r_span;
                    n_state = S_ARD;
                end else begin
                    n_node  = parent;
                    n_depth = r_depth - LV_W'(1);
                    n_off   = r_off - r_span;
                    n_span  = r_span << 1;
                end
            end
            S_FRD: n_state = S_FEV;
            S_FEV: begin
                priority if (r_ua) begin
                    we_u = 1'b1; we_s = 1'b1;
                    n_state = S_MRD;
                end else if (r_node == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_node  = parent;
                    n_state = S_FRD;
                end
            end
            S_MRD: n_state = (r_node == '0) ? S_DONE : S_MEV;
            S_MEV: begin
                if (r_ua || r_ub || r_sa || r_sb) begin
                    n_state = S_DONE;
                end else begin
                    we_s = 1'b1; wa_s = parent;
                    n_node  = parent;
                    n_state = S_MRD;
                end
            end
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // a configuration write to base, levels or minlog restarts the clearing pass
        if (cfg_xfer && i_cfg_index <= REG_MINLOG) n_state = S_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        if (we_u) mem_used[wa_u]  <= wd_u;
        if (we_s) mem_split[wa_s] <= wd_s;
        r_ua <= mem_used[r_node];
        r_sa <= mem_split[r_node];
        r_ub <= mem_used[buddy];
        r_sb <= mem_split[buddy];
    end

    always_ff @(posedge i_clk) begin
        r_node     <= n_node;
        r_depth    <= n_depth;
        r_span     <= n_span;
        r_off      <= n_off;
        r_req      <= n_req;
        r_res_addr <= n_res_addr;
        r_res_st   <= n_res_st;
        if (out_load) begin
            r_m_addr <= r_res_addr;
            r_m_st   <= r_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_m_valid <= 1'b0;
            r_base    <= '0;
            r_levels  <= 4'd11;
            r_minlog  <= 5'd5;
        end else begin
            r_state <= n_state;
            if (n_state == S_CLEAR && r_state != S_CLEAR) r_clr <= '0;
            else if (cfg_xfer && i_cfg_index <= REG_MINLOG) r_clr <= '0;
            else if (r_state == S_CLEAR)                   r_clr <= r_clr + NW'(1);
            if (out_load)                   r_m_valid <= 1'b1;
            else if (m_axis_tready)         r_m_valid <= 1'b0;
            if (cfg_xfer) begin
                unique case (i_cfg_index)
                    REG_BASE:   r_base   <= i_cfg_data;
                    REG_LEVELS: r_levels <= i_cfg_data[3:0];
                    REG_MINLOG: r_minlog <= i_cfg_data[MIN_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire
